>>> hdl/ppcb_pkg.sv
// ppcb_pkg.sv: shared types and constants of the packed pixel color key blitter
`timescale 1ns / 1ps

package ppcb_pkg;

  localparam int unsigned PIXELS_PER_WORD = 4;
  localparam int unsigned LANE_BITS       = 8;
  localparam int unsigned WORD_BITS       = PIXELS_PER_WORD * LANE_BITS;
  localparam int unsigned LANE_IDX_BITS   = $clog2(PIXELS_PER_WORD);
  localparam int unsigned COLOR_BITS      = 6;
  localparam int unsigned CFG_DATA_BITS   = COLOR_BITS;
  localparam int unsigned CFG_IDX_BITS    = 2;

  localparam logic [COLOR_BITS-1:0] KEY_COLOR_RESET = 6'd12;

  // configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_PIXEL_SHIFT      = 2'd0,
    REG_TRANSPARENT_MODE = 2'd1,
    REG_KEY_COLOR        = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [WORD_BITS-1:0]     src_word;
    logic [WORD_BITS-1:0]     dst_word;
    logic [LANE_IDX_BITS-1:0] first_lane;
    logic [LANE_IDX_BITS-1:0] last_lane;
    logic                     line_start;
    logic                     load_only;
  } in_item_t;

  typedef struct packed {
    logic [WORD_BITS-1:0]       out_word;
    logic [PIXELS_PER_WORD-1:0] lanes_written;
  } out_item_t;

  typedef struct packed {
    logic [LANE_IDX_BITS-1:0] pixel_shift;
    logic                     transparent_mode;
    logic [COLOR_BITS-1:0]    key_color;
  } blit_cfg_t;

endpackage

>>> hdl/ppcb_in_if.sv
// ppcb_in_if.sv: valid/ready channel carrying one source/destination word pair
`timescale 1ns / 1ps

interface ppcb_in_if;
  logic               valid;
  logic               ready;
  ppcb_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> hdl/ppcb_out_if.sv
// ppcb_out_if.sv: valid/ready channel carrying one merged framebuffer word
`timescale 1ns / 1ps

interface ppcb_out_if;
  logic                valid;
  logic                ready;
  ppcb_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> hdl/ppcb_merge.sv
// ppcb_merge.sv: lane alignment, clip and color key merge for one word
`timescale 1ns / 1ps

module ppcb_merge (
  input  ppcb_pkg::in_item_t               item,
  input  logic [ppcb_pkg::WORD_BITS-1:0]   prev_word,
  input  ppcb_pkg::blit_cfg_t              cfg,
  output ppcb_pkg::out_item_t              result
);

  localparam int unsigned WB = ppcb_pkg::WORD_BITS;
  localparam int unsigned LB = ppcb_pkg::LANE_BITS;
  localparam int unsigned NL = ppcb_pkg::PIXELS_PER_WORD;
  localparam int unsigned CB = ppcb_pkg::COLOR_BITS;

  logic [2*WB-1:0] pair_shifted;
  logic [WB-1:0]   block;
  logic [WB-1:0]   byte_mask;
  logic [NL-1:0]   lane_sel;

  // shifting the {current, previous} pair up leaves the aligned block on top
  assign pair_shifted = {item.src_word, prev_word} << (LB * cfg.pixel_shift);
  assign block        = pair_shifted[2*WB-1:WB];

  always_comb begin
    for (int lane = 0; lane < NL; lane++) begin
      lane_sel[lane] =
        (ppcb_pkg::LANE_IDX_BITS'(lane) >= item.first_lane) &&
        (ppcb_pkg::LANE_IDX_BITS'(lane) <= item.last_lane) &&
        !(cfg.transparent_mode && (block[lane*LB +: CB] == cfg.key_color));
      byte_mask[lane*LB +: LB] = {LB{lane_sel[lane]}};
    end
  end

  assign result.out_word      = (item.dst_word & ~byte_mask) | (block & byte_mask);
  assign result.lanes_written = lane_sel;

endmodule

>>> hdl/packed_pixel_color_key_blitter.sv
// packed_pixel_color_key_blitter.sv: top level of the packed pixel color key blitter
`timescale 1ns / 1ps

// channel    dir  handshake      payload
// in_ch      in   valid/ready    src_word, dst_word, first_lane, last_lane,
//                                line_start, load_only
// out_ch     out  valid/ready    out_word, lanes_written
// cfg_*      in   cfg_we only    cfg_index selects register, cfg_data value
//
// one transaction per cycle in, one per cycle out while out_ch is not stalled; a result
// goes from the input stage to the result register, with the single merge stage
// combinational between them
// rst_n is synchronous, active low; clears valids, previous source and config
// a stalled result holds the result register and, once the input stage holds a merge
// transaction behind it, drops in_ch.ready; load-only transactions never wait for out_ch

module packed_pixel_color_key_blitter (
  input  logic                                 clk,
  input  logic                                 rst_n,
  ppcb_in_if.sink                              in_ch,
  ppcb_out_if.source                           out_ch,
  input  logic                                 cfg_we,
  input  logic [ppcb_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [ppcb_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  localparam int unsigned WB = ppcb_pkg::WORD_BITS;

  // configuration registers
  ppcb_pkg::blit_cfg_t cfg_r;

  // previous source word, updated at every accepted transaction
  logic [WB-1:0] prev_r;
  logic [WB-1:0] prev_used;

  // input stage
  logic               s1_valid_r;
  ppcb_pkg::in_item_t s1_item_r;
  logic [WB-1:0]      s1_prev_r;

  // result register
  logic                out_valid_r;
  ppcb_pkg::out_item_t out_data_r;
  ppcb_pkg::out_item_t merged;

  logic in_acc;
  logic out_free;
  logic s1_move;
  logic s1_to_out;

  // config writes; the unused index is ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pixel_shift      <= '0;
      cfg_r.transparent_mode <= 1'b0;
      cfg_r.key_color        <= ppcb_pkg::KEY_COLOR_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ppcb_pkg::REG_PIXEL_SHIFT:
          cfg_r.pixel_shift <= cfg_data[ppcb_pkg::LANE_IDX_BITS-1:0];
        ppcb_pkg::REG_TRANSPARENT_MODE:
          cfg_r.transparent_mode <= cfg_data[0];
        ppcb_pkg::REG_KEY_COLOR:
          cfg_r.key_color <= cfg_data;
        default: ;
      endcase
    end
  end

  // handshake control
  assign out_free  = !out_valid_r || out_ch.ready;
  // a load-only entry retires without touching the result register
  assign s1_move   = s1_valid_r && (s1_item_r.load_only || out_free);
  assign s1_to_out = s1_move && !s1_item_r.load_only;
  assign in_ch.ready = !s1_valid_r || s1_move;
  assign in_acc    = in_ch.valid && in_ch.ready;

  // line start clears the previous word before this transaction uses it
  assign prev_used = in_ch.data.line_start ? '0 : prev_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
    end else if (in_acc) begin
      prev_r <= in_ch.data.src_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r <= in_ch.data;
      s1_prev_r <= prev_used;
    end
  end

  ppcb_merge u_merge (
    .item      (s1_item_r),
    .prev_word (s1_prev_r),
    .cfg       (cfg_r),
    .result    (merged)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_to_out;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_to_out) begin
      out_data_r <= merged;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  // a full input stage with a merge waiting behind a stalled result blocks input
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_item_r.load_only && out_valid_r && !out_ch.ready)
      |-> !in_ch.ready)
    else $error("input accepted while merge stage is stalled");

  // every accepted transaction leaves its source word as the previous word
  a_prev_tracks_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (prev_r == $past(in_ch.data.src_word)))
    else $error("previous source word not updated");

  // a result only appears behind a merge transaction in the input stage
  a_result_from_merge: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_valid_r && !s1_item_r.load_only))
    else $error("result appeared without a merge transaction");

  // an empty lane window writes nothing
  a_empty_window: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && (s1_item_r.first_lane > s1_item_r.last_lane))
      |-> (merged.lanes_written == '0))
    else $error("lanes written outside an empty lane window");

endmodule

>>> verif/tb_packed_pixel_color_key_blitter.sv
// tb_packed_pixel_color_key_blitter.sv: self-checking testbench of the color key blitter
`timescale 1ns / 1ps

module tb_packed_pixel_color_key_blitter;

  localparam int CLK_HALF_NS  = 1;
  localparam int RESET_CYCLES = 6;
  // drain margin, so a trailing load-only transaction settles
  localparam int DRAIN_CYCLES = 6;
  localparam int LIMIT_NS     = 1_000_000;
  localparam int NUM_PHASES   = 10;
  localparam int PHASE_ITEMS  = 53;

  // golden merge model plus the queue of merged words still owed by the block
  class blit_scoreboard;
    logic [ppcb_pkg::LANE_IDX_BITS-1:0] shift_lanes;
    logic                               skip_key;
    logic [ppcb_pkg::COLOR_BITS-1:0]    key_color;
    logic [ppcb_pkg::WORD_BITS-1:0]     prev_src;
    ppcb_pkg::out_item_t                merged_q[$];
    int                                 failures;

    function new();
      shift_lanes = '0;
      skip_key    = 1'b0;
      key_color   = ppcb_pkg::KEY_COLOR_RESET;
      prev_src    = '0;
      failures    = 0;
    endfunction

    function void write_reg(ppcb_pkg::cfg_reg_t idx,
                            logic [ppcb_pkg::CFG_DATA_BITS-1:0] val);
      case (idx)
        ppcb_pkg::REG_PIXEL_SHIFT:      shift_lanes = val[ppcb_pkg::LANE_IDX_BITS-1:0];
        ppcb_pkg::REG_TRANSPARENT_MODE: skip_key = val[0];
        ppcb_pkg::REG_KEY_COLOR:        key_color = val[ppcb_pkg::COLOR_BITS-1:0];
        default: ;
      endcase
    endfunction

    function void note_source(ppcb_pkg::in_item_t it);
      logic [ppcb_pkg::WORD_BITS-1:0] aligned;
      logic [ppcb_pkg::LANE_BITS-1:0] pix;
      ppcb_pkg::out_item_t            r;
      if (it.line_start) prev_src = '0;
      if (it.load_only) begin
        prev_src = it.src_word;
        return;
      end
      if (shift_lanes == '0) aligned = it.src_word;
      else aligned = (it.src_word << (8 * shift_lanes)) |
                     (prev_src >> (32 - 8 * shift_lanes));
      prev_src        = it.src_word;
      r.out_word      = it.dst_word;
      r.lanes_written = '0;
      for (int lane = 0; lane < ppcb_pkg::PIXELS_PER_WORD; lane++) begin
        pix = aligned[lane*8 +: 8];
        if (lane >= it.first_lane && lane <= it.last_lane &&
            !(skip_key && pix[ppcb_pkg::COLOR_BITS-1:0] == key_color)) begin
          r.out_word[lane*8 +: 8] = pix;
          r.lanes_written[lane]   = 1'b1;
        end
      end
      merged_q.push_back(r);
    endfunction

    function void check_merged(ppcb_pkg::out_item_t got);
      ppcb_pkg::out_item_t want;
      if (merged_q.size() == 0) begin
        $error("merged word with nothing pending: out_word %h lanes_written %b",
               got.out_word, got.lanes_written);
        failures++;
        return;
      end
      want = merged_q.pop_front();
      if (got.out_word !== want.out_word) begin
        $error("out_word mismatch: expected %h actual %h", want.out_word, got.out_word);
        failures++;
      end
      if (got.lanes_written !== want.lanes_written) begin
        $error("lanes_written mismatch: expected %b actual %b",
               want.lanes_written, got.lanes_written);
        failures++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [ppcb_pkg::CFG_IDX_BITS-1:0]  cfg_index;
  logic [ppcb_pkg::CFG_DATA_BITS-1:0] cfg_data;

  // when set, neither side inserts gaps or stalls (back-to-back stretches)
  bit no_idle;
  int sent_items;

  blit_scoreboard sb;

  ppcb_in_if  in_ch();
  ppcb_out_if out_ch();

  packed_pixel_color_key_blitter u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_HALF_NS) clk = ~clk;
  end

  // hard stop in case the handshake locks up
  initial begin
    #(LIMIT_NS);
    $display("Regression FAIL");
    $finish;
  end

  // mostly no gap, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  // pixel biased toward the key color so transparent skips happen often
  function automatic logic [ppcb_pkg::LANE_BITS-1:0] pick_pixel();
    if ($urandom_range(0, 2) == 0)
      return {2'($urandom_range(0, 3)), sb.key_color};
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [ppcb_pkg::WORD_BITS-1:0] pick_src();
    logic [ppcb_pkg::WORD_BITS-1:0] w;
    for (int lane = 0; lane < ppcb_pkg::PIXELS_PER_WORD; lane++)
      w[lane*8 +: 8] = pick_pixel();
    return w;
  endfunction

  // all tasks below are entered and left at a falling edge; inputs only change there
  task automatic send_item(input ppcb_pkg::in_item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.data  = it;
    // transaction happens at the first rising edge that sees ready high
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sb.note_source(it);
    sent_items++;
    @(negedge clk);
  endtask

  task automatic send_fields(input logic [ppcb_pkg::WORD_BITS-1:0] src,
                             input logic [ppcb_pkg::WORD_BITS-1:0] dst,
                             input logic [ppcb_pkg::LANE_IDX_BITS-1:0] first,
                             input logic [ppcb_pkg::LANE_IDX_BITS-1:0] last,
                             input bit ls, input bit lo);
    ppcb_pkg::in_item_t it;
    it.src_word   = src;
    it.dst_word   = dst;
    it.first_lane = first;
    it.last_lane  = last;
    it.line_start = ls;
    it.load_only  = lo;
    send_item(it);
  endtask

  // register writes are only legal with nothing in flight
  task automatic drain_pipeline();
    in_ch.valid = 1'b0;
    while (sb.merged_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // writes all three registers back to back, then drops the write enable
  task automatic apply_config(input logic [ppcb_pkg::LANE_IDX_BITS-1:0] shift,
                              input bit transp,
                              input logic [ppcb_pkg::COLOR_BITS-1:0] key);
    ppcb_pkg::cfg_reg_t                 idx [3];
    logic [ppcb_pkg::CFG_DATA_BITS-1:0] val [3];
    idx[0] = ppcb_pkg::REG_PIXEL_SHIFT;
    val[0] = ppcb_pkg::CFG_DATA_BITS'(shift);
    idx[1] = ppcb_pkg::REG_TRANSPARENT_MODE;
    val[1] = ppcb_pkg::CFG_DATA_BITS'(transp);
    idx[2] = ppcb_pkg::REG_KEY_COLOR;
    val[2] = key;
    for (int i = 0; i < 3; i++) begin
      cfg_we    = 1'b1;
      cfg_index = idx[i];
      cfg_data  = val[i];
      @(posedge clk);
      sb.write_reg(idx[i], val[i]);
      @(negedge clk);
    end
    cfg_we = 1'b0;
  endtask

  // one sprite row: optional left-clip prime, then words with ragged ends
  task automatic send_line();
    int len;
    bit prime;
    logic [ppcb_pkg::LANE_IDX_BITS-1:0] first;
    logic [ppcb_pkg::LANE_IDX_BITS-1:0] last;
    len   = $urandom_range(1, 8);
    prime = (sb.shift_lanes != '0) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 3) == 0);
    if (prime)
      send_fields(pick_src(), $urandom, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                  1'b1, 1'b1);
    for (int k = 0; k < len; k++) begin
      first = (k == 0)       ? 2'($urandom_range(0, 3)) : 2'd0;
      last  = (k == len - 1) ? 2'($urandom_range(0, 3)) : 2'd3;
      send_fields(pick_src(), $urandom, first, last, (k == 0) && !prime, 1'b0);
    end
  endtask

  // arbitrary transaction, including broken lines and stray loads
  task automatic send_noise();
    send_fields($urandom, $urandom, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0);
  endtask

  // result side: random ready with short and long stalls, checked at the rising edge
  initial begin : result_sink
    int stall_left;
    int r;
    stall_left = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (no_idle) begin
        out_ch.ready = 1'b1;
      end else if (stall_left > 0) begin
        out_ch.ready = 1'b0;
        stall_left--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          out_ch.ready = 1'b1;
        end else begin
          out_ch.ready = 1'b0;
          stall_left   = (r < 95) ? $urandom_range(0, 2) : $urandom_range(5, 25);
        end
      end
      @(posedge clk);
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) sb.check_merged(out_ch.data);
    end
  end

  initial begin : stimulus
    int budget;
    sb           = new();
    no_idle      = 1'b0;
    sent_items   = 0;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = ppcb_pkg::REG_PIXEL_SHIFT;
    cfg_data     = '0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: reset settings, shift zero so the block is the current word alone
    send_fields(32'hffff_ffff, 32'h0000_0000, 2'd0, 2'd3, 1'b1, 1'b0);
    send_fields(32'h0000_0000, 32'hffff_ffff, 2'd0, 2'd3, 1'b0, 1'b0);
    // first lane above last lane: destination passes through untouched
    send_fields(32'h1234_5678, 32'hdead_beef, 2'd2, 2'd1, 1'b0, 1'b0);
    send_fields(32'ha5a5_a5a5, 32'h5a5a_5a5a, 2'd3, 2'd3, 1'b0, 1'b0);
    // key colored pixels are copied while transparency is off
    send_fields(32'h0c0c_0c0c, 32'h3333_3333, 2'd0, 2'd0, 1'b0, 1'b0);

    // transparent with the reset key, one lane shift
    drain_pipeline();
    apply_config(2'd1, 1'b1, ppcb_pkg::KEY_COLOR_RESET);
    // line start together with load only: clear, then prime
    send_fields(32'h8899_aabb, 32'h0000_0000, 2'd0, 2'd3, 1'b1, 1'b1);
    send_fields(32'h4c8c_cc0c, 32'h1122_3344, 2'd0, 2'd3, 1'b0, 1'b0);
    send_fields(32'h0d0c_4d0c, 32'h5566_7788, 2'd1, 2'd3, 1'b0, 1'b0);
    send_fields(32'hffee_ddcc, 32'h99aa_bbcc, 2'd0, 2'd2, 1'b0, 1'b0);

    // widest shift, top key value
    drain_pipeline();
    apply_config(2'd3, 1'b1, 6'd63);
    send_fields(32'hff7f_bf3f, 32'h0000_0000, 2'd0, 2'd3, 1'b1, 1'b1);
    send_fields(32'h3f00_ff01, 32'h8765_4321, 2'd0, 2'd3, 1'b0, 1'b0);
    send_fields(32'h0102_0304, 32'hfedc_ba98, 2'd3, 2'd0, 1'b0, 1'b0);
    // line start without prime: lower lanes come from a zero word
    send_fields(32'hc3c3_c3c3, 32'h0f0f_0f0f, 2'd1, 2'd3, 1'b1, 1'b0);

    drain_pipeline();
    apply_config(2'd2, 1'b0, 6'd0);
    send_fields(32'h0000_0000, 32'hffff_ffff, 2'd0, 2'd3, 1'b1, 1'b0);
    send_fields(32'hcafe_f00d, 32'h0000_0000, 2'd2, 2'd3, 1'b0, 1'b0);
    // load only in mid line replaces the previous word
    send_fields(32'h1111_1111, 32'h0000_0000, 2'd0, 2'd3, 1'b0, 1'b1);
    send_fields(32'h3333_3333, 32'h2222_2222, 2'd0, 2'd3, 1'b0, 1'b0);

    // key zero: every pixel with clear low bits is skipped
    drain_pipeline();
    apply_config(2'd0, 1'b1, 6'd0);
    send_fields(32'hc040_8000, 32'h7777_7777, 2'd0, 2'd3, 1'b1, 1'b0);
    send_fields(32'h0102_0304, 32'h5555_5555, 2'd0, 2'd3, 1'b0, 1'b0);

    // random phases, each under its own settings; phase 0 and 1 pin the extremes
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      drain_pipeline();
      no_idle = (phase % 4 == 3);
      if (phase == 0)      apply_config(2'd3, 1'b0, 6'd63);
      else if (phase == 1) apply_config(2'd0, 1'b1, 6'd0);
      else apply_config(2'($urandom_range(0, 3)), $urandom_range(0, 2) != 0,
                        6'($urandom_range(0, 63)));
      budget = sent_items + PHASE_ITEMS;
      while (sent_items < budget) begin
        if ($urandom_range(0, 4) != 0) send_line();
        else send_noise();
      end
    end

    // let every owed word come out, then watch for strays
    drain_pipeline();
    no_idle = 1'b0;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.failures == 0 && sb.merged_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
